// ----- hdl/segment_display_frame_writer_core_macros.svh -----
// Assertion macros for the segment display frame writer.
`ifndef SEGMENT_DISPLAY_FRAME_WRITER_CORE_MACROS_SVH
`define SEGMENT_DISPLAY_FRAME_WRITER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on i_clk and disabled during reset.
`define SDFW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on i_clk and disabled during reset.
`define SDFW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SDFW_ASSERT_IMP(lbl, ante, cons, msg)
`define SDFW_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hdl/sdfw_pkg.sv -----
// Shared types, constants and helper functions of the segment display frame writer.
`default_nettype none

package sdfw_pkg;

    localparam int NUM_DIGITS_DEF = 4;
    localparam int QUEUE_DEPTH    = 2;

    localparam int CFG_W      = 3;
    localparam int CFG_ADDR_W = 2;

    // Item kinds carried in tuser.
    localparam logic [1:0] KIND_UPDATE = 2'd0;
    localparam logic [1:0] KIND_ON     = 2'd1;
    localparam logic [1:0] KIND_OFF    = 2'd2;
    localparam logic [1:0] KIND_RSVD   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_BRIGHTNESS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_POINT      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLANK      = 2'd2;

    localparam logic [2:0] RST_BRIGHTNESS = 3'd5;
    localparam logic [2:0] RST_POINT      = 3'd4;
    localparam logic       RST_BLANK      = 1'b1;

    // Display controller command bytes.
    localparam logic [7:0] CMD_DATA = 8'h40;
    localparam logic [7:0] CMD_ADDR = 8'hC0;
    localparam logic [7:0] CMD_ON   = 8'h88;
    localparam logic [7:0] CMD_OFF  = 8'h80;
    localparam logic [7:0] SEG_DP   = 8'h80;

    typedef struct packed {
        logic [2:0] brightness;
        logic [2:0] point_position;
        logic       blank_leading_zeros;
    } t_cfg;

    typedef struct packed {
        logic [15:0] quo;
        logic [3:0]  rem;
    } t_div;

    // Seven-segment pattern of one decimal digit.
    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3f;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5b;
            4'd3:    s = 8'h4f;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6d;
            4'd6:    s = 8'h7d;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7f;
            4'd9:    s = 8'h6f;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // Division of a 16-bit value by ten through the reciprocal 52429 / 2^19,
    // which is exact over the whole 16-bit range.
    function automatic t_div div10(input logic [15:0] x);
        logic [32:0] prod;
        logic [15:0] q;
        logic [15:0] q10;
        t_div        res;
        prod    = {17'd0, x} * 33'd52429;
        q       = {2'd0, prod[32:19]};
        q10     = {q[12:0], 3'd0} + {q[14:0], 1'b0};
        res.quo = q;
        res.rem = 4'(x - q10);
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/sdfw_front.sv -----
// Front end: digit extraction pipeline, blanking and segment encoding.
`default_nettype none

module sdfw_front #(
    parameter int NUM_DIGITS = sdfw_pkg::NUM_DIGITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire  sdfw_pkg::t_cfg       i_cfg,
    input  wire                        i_valid,
    output logic                       o_ready,
    input  wire  [1:0]                 i_kind,
    input  wire  [15:0]                i_number,
    output logic                       o_push,
    input  wire                        i_q_ready,
    output logic [8*NUM_DIGITS+1:0]    o_entry
);

    logic                           r_vld  [NUM_DIGITS];
    logic [1:0]                     r_kind [NUM_DIGITS];
    logic [15:0]                    r_quo  [NUM_DIGITS];
    logic [NUM_DIGITS-1:0][3:0]     r_dig  [NUM_DIGITS];
    sdfw_pkg::t_div                 w_div  [NUM_DIGITS];
    logic                           w_rdy  [NUM_DIGITS+1];

    logic [NUM_DIGITS-1:0][3:0]     w_fin_dig;
    logic [NUM_DIGITS-1:0][7:0]     w_seg;
    logic                           w_blank;
    logic                           w_drop;

    // Reserved kinds leave the pipeline without reaching the queue.
    assign w_drop            = (r_kind[NUM_DIGITS-1] == sdfw_pkg::KIND_RSVD);
    assign w_rdy[NUM_DIGITS] = i_q_ready || w_drop;
    assign o_push            = r_vld[NUM_DIGITS-1] && !w_drop && i_q_ready;
    assign o_ready           = w_rdy[0];

    for (genvar s = 0; s < NUM_DIGITS; s++) begin : g_stage
        logic                       n_vld;
        logic [1:0]                 n_kind;
        logic [15:0]                n_quo;
        logic [NUM_DIGITS-1:0][3:0] n_dig;

        assign w_div[s] = sdfw_pkg::div10(r_quo[s]);
        assign w_rdy[s] = !r_vld[s] || w_rdy[s+1];

        if (s == 0) begin : g_first
            always_comb begin
                n_vld  = i_valid;
                n_kind = i_kind;
                n_quo  = i_number;
                n_dig  = '0;
            end
        end else begin : g_next
            // Each stage fills one digit, the rightmost first.
            always_comb begin
                n_vld             = r_vld[s-1];
                n_kind            = r_kind[s-1];
                n_quo             = w_div[s-1].quo;
                n_dig             = r_dig[s-1];
                n_dig[NUM_DIGITS-s] = w_div[s-1].rem;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_rdy[s]) begin
                r_vld[s] <= n_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[s] && n_vld) begin
                r_kind[s] <= n_kind;
                r_quo[s]  <= n_quo;
                r_dig[s]  <= n_dig;
            end
        end
    end

    always_comb begin
        w_fin_dig    = r_dig[NUM_DIGITS-1];
        w_fin_dig[0] = w_div[NUM_DIGITS-1].rem;
    end

    // When leading-zero blanking is on, leading zeros are blanked until the first
    // nonzero digit; the rightmost digit always shows.
    always_comb begin
        w_blank = i_cfg.blank_leading_zeros;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (w_blank && (w_fin_dig[i] == 4'd0)) begin
                w_seg[i] = (i < NUM_DIGITS - 1) ? 8'h00 : sdfw_pkg::seg_of(4'd0);
            end else begin
                w_blank  = 1'b0;
                w_seg[i] = sdfw_pkg::seg_of(w_fin_dig[i]) |
                           ((i_cfg.point_position == 3'(i)) ? sdfw_pkg::SEG_DP : 8'h00);
            end
        end
    end

    assign o_entry = {w_seg, r_kind[NUM_DIGITS-1]};

endmodule

`default_nettype wire

// ----- hdl/sdfw_queue.sv -----
// Small register queue that decouples the front end from the byte sequencer.
`default_nettype none

module sdfw_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sdfw_pkg::QUEUE_DEPTH
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire  [WIDTH-1:0] i_data,
    output logic             o_ready,
    input  wire              i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sdfw_back.sv -----
// Back end: byte sequencer that turns queued entries into framed bytes.
`default_nettype none

module sdfw_back #(
    parameter int NUM_DIGITS = sdfw_pkg::NUM_DIGITS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire  sdfw_pkg::t_cfg     i_cfg,
    input  wire                      i_q_valid,
    input  wire  [8*NUM_DIGITS+1:0]  i_q_data,
    output logic                     o_pop,
    output logic                     o_tvalid,
    input  wire                      i_tready,
    output logic [7:0]               o_tdata,
    output logic [1:0]               o_tuser,
    output logic                     o_tlast
);

    localparam int IDX_W = $clog2(NUM_DIGITS + 3);

    logic [1:0]                 w_kind;
    logic [NUM_DIGITS-1:0][7:0] w_seg;
    logic [7:0]                 w_byte;
    logic                       w_start;
    logic                       w_stop;
    logic                       w_last;
    logic [7:0]                 w_on_byte;
    logic                       w_load;

    logic [IDX_W-1:0]           r_idx;
    logic                       r_vld;
    logic [7:0]                 r_byte;
    logic [1:0]                 r_user;
    logic                       r_last;

    assign w_kind    = i_q_data[1:0];
    assign w_seg     = i_q_data[8*NUM_DIGITS+1:2];
    assign w_on_byte = sdfw_pkg::CMD_ON + {5'd0, i_cfg.brightness};
    assign w_load    = !r_vld || i_tready;
    assign o_pop     = w_load && i_q_valid && w_last;

    always_comb begin
        w_byte  = 8'h00;
        w_start = 1'b0;
        w_stop  = 1'b0;
        w_last  = 1'b0;
        case (w_kind)
            sdfw_pkg::KIND_ON: begin
                w_byte  = w_on_byte;
                w_start = 1'b1;
                w_stop  = 1'b1;
                w_last  = 1'b1;
            end
            sdfw_pkg::KIND_OFF: begin
                w_byte  = sdfw_pkg::CMD_OFF;
                w_start = 1'b1;
                w_stop  = 1'b1;
                w_last  = 1'b1;
            end
            sdfw_pkg::KIND_UPDATE: begin
                if (r_idx == IDX_W'(0)) begin
                    w_byte  = sdfw_pkg::CMD_DATA;
                    w_start = 1'b1;
                    w_stop  = 1'b1;
                end else if (r_idx == IDX_W'(1)) begin
                    w_byte  = sdfw_pkg::CMD_ADDR;
                    w_start = 1'b1;
                end else if (r_idx == IDX_W'(NUM_DIGITS + 2)) begin
                    w_byte  = w_on_byte;
                    w_start = 1'b1;
                    w_stop  = 1'b1;
                    w_last  = 1'b1;
                end else begin
                    for (int j = 0; j < NUM_DIGITS; j++) begin
                        if (r_idx == IDX_W'(j + 2)) begin
                            w_byte = w_seg[j];
                            w_stop = (j == NUM_DIGITS - 1);
                        end
                    end
                end
            end
            default: begin
                w_byte = 8'h00;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= '0;
        end else if (w_load) begin
            r_vld <= i_q_valid;
            if (i_q_valid) begin
                r_idx <= w_last ? '0 : r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_q_valid) begin
            r_byte <= w_byte;
            r_user <= {w_stop, w_start};
            r_last <= w_last;
        end
    end

    assign o_tvalid = r_vld;
    assign o_tdata  = r_byte;
    assign o_tuser  = r_user;
    assign o_tlast  = r_last;

endmodule

`default_nettype wire

// ----- hdl/segment_display_frame_writer_core.sv -----
// A taken word is registered in the digit stages, then in the queue, then in the output register.
// An update is sent as NUM_DIGITS + 3 bytes (7 at four digits), on and off as one byte each,
// as built by the back-end byte sequencer, which emits one byte per cycle unless i_tready stalls it.
// The digit pipeline and the two-entry queue take new words while bytes are still going out.
// Reset (synchronous, active low) empties the pipeline, queue and output register and
// returns brightness to 5, point position to 4 and leading-zero blanking to on.
`default_nettype none

`include "segment_display_frame_writer_core_macros.svh"

module segment_display_frame_writer_core #(
    parameter int NUM_DIGITS = sdfw_pkg::NUM_DIGITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Update words in.
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [15:0]                      s_axis_tdata,  // [15:0] number
    input  wire  [1:0]                       s_axis_tuser,  // [1:0] kind
    // Frame bytes out.
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [7:0]                       m_axis_tdata,  // [7:0] frame_byte
    output logic [1:0]                       m_axis_tuser,  // [0] start_before, [1] stop_after
    output logic                             m_axis_tlast,
    // Configuration writes.
    input  wire                              i_cfg_we,
    input  wire  [sdfw_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire  [sdfw_pkg::CFG_W-1:0]       i_cfg_wdata
);

    localparam int ENTRY_W = 8 * NUM_DIGITS + 2;

    logic [2:0]         r_brightness;
    logic [2:0]         r_point;
    logic               r_blank;
    sdfw_pkg::t_cfg     w_cfg;

    logic               w_push;
    logic               w_q_ready;
    logic               w_q_valid;
    logic               w_pop;
    logic [ENTRY_W-1:0] w_entry_in;
    logic [ENTRY_W-1:0] w_entry_out;

    // Configuration registers; writes to indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= sdfw_pkg::RST_BRIGHTNESS;
            r_point      <= sdfw_pkg::RST_POINT;
            r_blank      <= sdfw_pkg::RST_BLANK;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sdfw_pkg::CFG_BRIGHTNESS: r_brightness <= i_cfg_wdata;
                sdfw_pkg::CFG_POINT:      r_point      <= i_cfg_wdata;
                sdfw_pkg::CFG_BLANK:      r_blank      <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.brightness          = r_brightness;
    assign w_cfg.point_position      = r_point;
    assign w_cfg.blank_leading_zeros = r_blank;

    // The front end splits the number into decimal digits, one per stage, and
    // encodes the segment bytes when the last digit is known.
    sdfw_front #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_kind    (s_axis_tuser),
        .i_number  (s_axis_tdata),
        .o_push    (w_push),
        .i_q_ready (w_q_ready),
        .o_entry   (w_entry_in)
    );

    // The queue holds encoded entries so that the front end keeps taking words
    // while a frame is still going out.
    sdfw_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (sdfw_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_entry_in),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_entry_out)
    );

    // The back end walks through the bytes of the head entry and releases it
    // together with its last byte.
    sdfw_back #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_entry_out),
        .o_pop     (w_pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tuser   (m_axis_tuser),
        .o_tlast   (m_axis_tlast)
    );

    // A push is only issued when the queue has room.
    `SDFW_ASSERT_IMP(a_push_has_room, w_push, w_q_ready, "push into a full queue")
    // An entry is only released when the queue holds one.
    `SDFW_ASSERT_IMP(a_pop_has_entry, w_pop, w_q_valid, "pop from an empty queue")
    // The closing byte of every frame carries both start and stop conditions.
    `SDFW_ASSERT_IMP(a_last_framed, m_axis_tvalid && m_axis_tlast,
                     m_axis_tuser == 2'b11, "closing byte without start and stop")
    // Within one item the bytes follow each other without a gap.
    `SDFW_ASSERT_NXT(a_no_gap, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
                     m_axis_tvalid, "gap inside a frame")

endmodule

`default_nettype wire
